>>> hw/rtl/psu_presence_monitor_and_commander_assert.svh
// assertion macros for the supply presence monitor and commander
// no dependencies; included by the top level
`ifndef PSU_PRESENCE_MONITOR_AND_COMMANDER_ASSERT_SVH
`define PSU_PRESENCE_MONITOR_AND_COMMANDER_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define PPMC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication failed");

// next-cycle implication, off while reset is asserted
`define PPMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

>>> hw/rtl/ppmc_pkg.sv
// shared types and constants for the supply presence monitor and commander
// no dependencies
package ppmc_pkg;

	// item modes
	localparam logic [1:0] MODE_TICK     = 2'd0;
	localparam logic [1:0] MODE_SETPOINT = 2'd1;
	localparam logic [1:0] MODE_OFF      = 2'd2;

	// result kinds
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_WRITE  = 1'b1;

	// supply registers and commands
	localparam logic [7:0] CTRL_REG   = 8'h7C;
	localparam logic [7:0] VOLT_REG   = 8'h70;
	localparam logic [7:0] CURR_REG   = 8'h72;
	localparam logic [7:0] CMD_REMOTE = 8'h80;
	localparam logic [7:0] CMD_COMMIT = 8'h84;
	localparam logic [7:0] CMD_ON     = 8'h85;
	localparam logic [1:0] LEN_BYTE   = 2'd1;
	localparam logic [1:0] LEN_HALF   = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_STALE_STEP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALIVE_CAP     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VOLT_DEADBAND = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CURR_DEADBAND = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_DEADBAND = 3'd5;

	// reset values
	localparam logic [12:0] STALE_STEP_RST    = 13'd200;
	localparam logic [12:0] ALIVE_CAP_RST     = 13'd5000;
	localparam logic [12:0] PRESENT_LIMIT_RST = 13'd1000;
	localparam logic [15:0] VOLT_DEADBAND_RST = 16'd5;
	localparam logic [15:0] CURR_DEADBAND_RST = 16'd5;
	localparam logic [7:0]  TEMP_DEADBAND_RST = 8'd0;
	localparam logic [12:0] ALIVE_COUNT_RST   = 13'd1000;
	localparam logic [12:0] ALIVE_COUNT_MAX   = 13'd8191;

	// results per item
	localparam logic [2:0] NRES_SETPOINT = 3'd6;

	typedef struct packed {
		logic [1:0]  mode;
		logic        ok_volt;
		logic        ok_curr;
		logic        ok_temp;
		logic        ok_ctrl;
		logic [15:0] raw_volt;
		logic [15:0] raw_curr;
		logic [7:0]  raw_temp;
		logic [7:0]  ctrl_byte;
		logic [15:0] set_volt_centi;
		logic [15:0] set_curr_centi;
	} in_word_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  reg_addr;
		logic [1:0]  write_len;
		logic [15:0] write_data;
		logic        present;
		logic        out_enabled;
		logic [15:0] volt_centi;
		logic [15:0] curr_centi;
		logic [7:0]  temp_c;
		logic        temp_valid;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic [12:0] stale_step;
		logic [12:0] alive_cap;
		logic [12:0] present_limit;
		logic [15:0] volt_deadband;
		logic [15:0] curr_deadband;
		logic [7:0]  temp_deadband;
	} cfg_t;

	// monitor view of the word in the input register
	typedef struct packed {
		logic        present;
		logic        on_now;
		logic        pub;
		logic        present_nxt;
		logic        on_nxt;
		logic [15:0] volt_nxt;
		logic [15:0] curr_nxt;
		logic [7:0]  temp_nxt;
	} mon_t;

	// sequencer status
	typedef struct packed {
		logic commit;
		logic busy;
	} seq_t;

endpackage

>>> hw/rtl/ppmc_cfg_regs.sv
// configuration registers for the supply presence monitor and commander
// depends on ppmc_pkg
module ppmc_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ppmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ppmc_pkg::CFG_DATA_W-1:0] cfg_data,
	output ppmc_pkg::cfg_t                  cfg
);
	import ppmc_pkg::*;

	cfg_t cfg_q;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stale_step    <= STALE_STEP_RST;
			cfg_q.alive_cap     <= ALIVE_CAP_RST;
			cfg_q.present_limit <= PRESENT_LIMIT_RST;
			cfg_q.volt_deadband <= VOLT_DEADBAND_RST;
			cfg_q.curr_deadband <= CURR_DEADBAND_RST;
			cfg_q.temp_deadband <= TEMP_DEADBAND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STALE_STEP:    cfg_q.stale_step    <= cfg_data[12:0];
				CFG_ALIVE_CAP:     cfg_q.alive_cap     <= cfg_data[12:0];
				CFG_PRESENT_LIMIT: cfg_q.present_limit <= cfg_data[12:0];
				CFG_VOLT_DEADBAND: cfg_q.volt_deadband <= cfg_data;
				CFG_CURR_DEADBAND: cfg_q.curr_deadband <= cfg_data;
				CFG_TEMP_DEADBAND: cfg_q.temp_deadband <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/ppmc_monitor.sv
// alive tracking, stored measurements and publish decision
// depends on ppmc_pkg
module ppmc_monitor (
	input  logic               clk,
	input  logic               arst_n,
	input  ppmc_pkg::cfg_t     cfg,
	input  ppmc_pkg::in_word_t item_s1,
	input  logic               commit,
	output ppmc_pkg::mon_t     mon
);
	import ppmc_pkg::*;

	logic [12:0] alive_q;
	logic        present_q;
	logic        on_q;
	logic [15:0] volt_q;
	logic [15:0] curr_q;
	logic [7:0]  temp_q;
	logic        pub_once_q;
	logic        pub_present_q;
	logic        pub_on_q;
	logic [15:0] pub_volt_q;
	logic [15:0] pub_curr_q;
	logic [7:0]  pub_temp_q;

	logic        any_ok;
	logic [13:0] alive_sum;
	logic [12:0] alive_nxt;
	logic        present_nxt;
	logic        on_nxt;
	logic [15:0] volt_nxt;
	logic [15:0] curr_nxt;
	logic [7:0]  temp_nxt;
	logic [15:0] volt_diff;
	logic [15:0] curr_diff;
	logic [7:0]  temp_diff;
	logic        pub;

	// next alive count and measurements for a tick
	always_comb begin
		any_ok    = item_s1.ok_volt | item_s1.ok_curr | item_s1.ok_temp | item_s1.ok_ctrl;
		alive_sum = {1'b0, alive_q} + {1'b0, cfg.stale_step};
		if (any_ok) begin
			alive_nxt = '0;
		end else if (alive_q < cfg.alive_cap) begin
			alive_nxt = alive_sum[13] ? ALIVE_COUNT_MAX : alive_sum[12:0];
		end else begin
			alive_nxt = alive_q;
		end
		present_nxt = (alive_nxt <= cfg.present_limit);
		volt_nxt    = item_s1.ok_volt ? item_s1.raw_volt : volt_q;
		curr_nxt    = item_s1.ok_curr ? item_s1.raw_curr : curr_q;
		temp_nxt    = item_s1.ok_temp ? item_s1.raw_temp : temp_q;
		on_nxt      = item_s1.ok_ctrl ? item_s1.ctrl_byte[0] : on_q;
	end

	// deadband checks against the last published values
	always_comb begin
		volt_diff = (volt_nxt > pub_volt_q) ? volt_nxt - pub_volt_q : pub_volt_q - volt_nxt;
		curr_diff = (curr_nxt > pub_curr_q) ? curr_nxt - pub_curr_q : pub_curr_q - curr_nxt;
		temp_diff = (temp_nxt > pub_temp_q) ? temp_nxt - pub_temp_q : pub_temp_q - temp_nxt;
		pub = !pub_once_q
			|| (present_nxt != pub_present_q)
			|| (on_nxt != pub_on_q)
			|| (volt_diff > cfg.volt_deadband)
			|| (curr_diff > cfg.curr_deadband)
			|| (temp_diff > cfg.temp_deadband);
	end

	// state update when the word leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q       <= ALIVE_COUNT_RST;
			present_q     <= 1'b0;
			on_q          <= 1'b0;
			volt_q        <= '0;
			curr_q        <= '0;
			temp_q        <= '0;
			pub_once_q    <= 1'b0;
			pub_present_q <= 1'b0;
			pub_on_q      <= 1'b0;
			pub_volt_q    <= '0;
			pub_curr_q    <= '0;
			pub_temp_q    <= '0;
		end else if (commit) begin
			if (item_s1.mode == MODE_TICK) begin
				alive_q   <= alive_nxt;
				present_q <= present_nxt;
				on_q      <= on_nxt;
				volt_q    <= volt_nxt;
				curr_q    <= curr_nxt;
				temp_q    <= temp_nxt;
				if (pub) begin
					pub_once_q    <= 1'b1;
					pub_present_q <= present_nxt;
					pub_on_q      <= on_nxt;
					pub_volt_q    <= volt_nxt;
					pub_curr_q    <= curr_nxt;
					pub_temp_q    <= temp_nxt;
				end
			end else if (item_s1.mode == MODE_SETPOINT && present_q) begin
				on_q <= 1'b1;
			end
		end
	end

	always_comb begin
		mon.present     = present_q;
		mon.on_now      = on_q;
		mon.pub         = pub;
		mon.present_nxt = present_nxt;
		mon.on_nxt      = on_nxt;
		mon.volt_nxt    = volt_nxt;
		mon.curr_nxt    = curr_nxt;
		mon.temp_nxt    = temp_nxt;
	end

endmodule

>>> hw/rtl/ppmc_sequencer.sv
// input register, result sequencing and output register
// depends on ppmc_pkg
module ppmc_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  ppmc_pkg::in_word_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output ppmc_pkg::out_word_t result,
	input  ppmc_pkg::mon_t      mon,
	output ppmc_pkg::in_word_t  item_s1,
	output ppmc_pkg::seq_t      sts
);
	import ppmc_pkg::*;

	logic      valid_s1;
	in_word_t  word_s1;
	logic [2:0] idx_q;
	logic      out_valid_q;
	out_word_t out_q;

	logic      [2:0] n_res;
	logic      load_out;
	logic      done;
	out_word_t res;

	// number of results for the word in the input register
	always_comb begin
		case (word_s1.mode)
			MODE_TICK:     n_res = mon.pub ? 3'd1 : 3'd0;
			MODE_SETPOINT: n_res = mon.present ? NRES_SETPOINT : 3'd0;
			MODE_OFF:      n_res = 3'd1;
			default:       n_res = 3'd0;
		endcase
		load_out   = valid_s1 && (n_res != 3'd0) && (!out_valid_q || result_ready);
		done       = valid_s1 && ((n_res == 3'd0) || (load_out && idx_q == n_res - 3'd1));
		item_ready = !valid_s1 || done;
	end

	// result word selected by mode and position
	always_comb begin
		res = '0;
		case (word_s1.mode)
			MODE_TICK: begin
				res.kind        = KIND_STATUS;
				res.present     = mon.present_nxt;
				res.out_enabled = mon.on_nxt;
				res.volt_centi  = mon.volt_nxt;
				res.curr_centi  = mon.curr_nxt;
				res.temp_c      = mon.temp_nxt;
				res.temp_valid  = 1'b1;
				res.last        = 1'b1;
			end
			MODE_SETPOINT: begin
				case (idx_q)
					3'd0: begin
						res.kind       = KIND_WRITE;
						res.reg_addr   = CTRL_REG;
						res.write_len  = LEN_BYTE;
						res.write_data = {8'd0, CMD_REMOTE};
					end
					3'd1: begin
						res.kind       = KIND_WRITE;
						res.reg_addr   = VOLT_REG;
						res.write_len  = LEN_HALF;
						res.write_data = word_s1.set_volt_centi;
					end
					3'd2: begin
						res.kind       = KIND_WRITE;
						res.reg_addr   = CURR_REG;
						res.write_len  = LEN_HALF;
						res.write_data = word_s1.set_curr_centi;
					end
					3'd3: begin
						res.kind       = KIND_WRITE;
						res.reg_addr   = CTRL_REG;
						res.write_len  = LEN_BYTE;
						res.write_data = {8'd0, CMD_COMMIT};
					end
					3'd4: begin
						res.kind       = KIND_WRITE;
						res.reg_addr   = CTRL_REG;
						res.write_len  = LEN_BYTE;
						res.write_data = {8'd0, CMD_ON};
					end
					default: begin
						// closing status of a setpoint
						res.kind        = KIND_STATUS;
						res.present     = 1'b1;
						res.out_enabled = 1'b1;
						res.volt_centi  = word_s1.set_volt_centi;
						res.last        = 1'b1;
					end
				endcase
			end
			MODE_OFF: begin
				res.kind       = KIND_WRITE;
				res.reg_addr   = CTRL_REG;
				res.write_len  = LEN_BYTE;
				res.write_data = {8'd0, CMD_REMOTE};
				res.last       = 1'b1;
			end
			default: ;
		endcase
	end

	// input register and result position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (item_valid && item_ready) begin
				valid_s1 <= 1'b1;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
			if (done) begin
				idx_q <= '0;
			end else if (load_out) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			word_s1 <= item;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign item_s1      = word_s1;
	assign sts          = '{commit: done, busy: valid_s1};

endmodule

>>> hw/rtl/psu_presence_monitor_and_commander.sv
// top level of the supply presence monitor and commander
// depends on ppmc_pkg, ppmc_cfg_regs, ppmc_monitor, ppmc_sequencer and the assert header
//
// channel   | signals                               | word
// ----------+---------------------------------------+--------------------
// item      | item_valid / item_ready / item        | ppmc_pkg::in_word_t
// result    | result_valid / result_ready / result  | ppmc_pkg::out_word_t
// config    | cfg_we / cfg_index / cfg_data         | 16 bit write data
//
// tick and off words pass the input register at one word per cycle unless results stall
// a setpoint holds the input register for six results, one per cycle unless stalled
// a word with no results leaves the input register without waiting for the output
// results are formed combinationally and reach the port through the output register
// a stalled result holds the output register and the input register behind it
// reset clears the state and loads the configuration defaults at once
`include "psu_presence_monitor_and_commander_assert.svh"

module psu_presence_monitor_and_commander (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  ppmc_pkg::in_word_t              item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output ppmc_pkg::out_word_t             result,
	input  logic                            cfg_we,
	input  logic [ppmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ppmc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ppmc_pkg::*;

	cfg_t     cfg;
	mon_t     mon;
	in_word_t item_s1;
	seq_t     sts;

	ppmc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ppmc_monitor u_mon (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item_s1 (item_s1),
		.commit  (sts.commit),
		.mon     (mon)
	);

	ppmc_sequencer u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.mon          (mon),
		.item_s1      (item_s1),
		.sts          (sts)
	);

	// checks
	`PPMC_ASSERT_NOW(a_ready_only_when_busy, clk, arst_n, !item_ready, sts.busy)
	`PPMC_ASSERT_NOW(a_write_fields_clear, clk, arst_n, result_valid && result.kind == KIND_WRITE, !result.present && !result.temp_valid && !result.out_enabled)
	`PPMC_ASSERT_NEXT(a_setpoint_turns_on, clk, arst_n, sts.commit && item_s1.mode == MODE_SETPOINT && mon.present, mon.on_now)

endmodule
